>>> hw/rtl/pktlog_pkg.sv
`default_nettype none

package pktlog_pkg;

   // Operation codes carried on the request tuser.
   typedef enum logic [1:0] {
      OP_LOG   = 2'd0,
      OP_START = 2'd1,
      OP_READ  = 2'd2,
      OP_CLEAR = 2'd3
   } op_type;

   // Status codes carried on the response tuser.
   typedef enum logic [2:0] {
      ST_INSERTED = 3'd0,
      ST_UPDATED  = 3'd1,
      ST_FULL     = 3'd2,
      ST_ROW      = 3'd3,
      ST_NO_MORE  = 3'd4,
      ST_DONE     = 3'd5
   } status_type;

   // Sequencer states.
   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_SCAN,
      SEQ_READ,
      SEQ_RESP
   } seq_state_type;

   localparam int unsigned ADDRS_W = 64;
   localparam int unsigned CODES_W = 49;
   localparam int unsigned STAMP_W = 32;
   localparam int unsigned HITS_W  = 32;

   // One table row. Addresses hold the source address in the high half.
   // Codes hold source port, destination port, protocol, reason and verdict,
   // from the highest bits down; the verdict is not part of the flow key.
   typedef struct packed {
      logic [ADDRS_W-1:0] addrs;
      logic [CODES_W-1:0] codes;
      logic [STAMP_W-1:0] stamp;
      logic [HITS_W-1:0]  hits;
   } entry_type;

   localparam int unsigned ENTRY_W = $bits(entry_type);

endpackage

`default_nettype wire

>>> hw/rtl/pktlog_ram.sv
`default_nettype none

module pktlog_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Single write port, single registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule

`default_nettype wire

>>> hw/rtl/packet_log_match_or_insert_table.sv
`default_nettype none
// Channel   Direction  Handshake              tuser           tdata
// req       in         req_tvalid/req_tready  op (2 bits)     event and flow key, 152 bits
// rsp       out        rsp_tvalid/rsp_tready  status (3 bits) returned row, 184 bits
//
// A log event reads one stored row per cycle: a miss scans every stored row
// before it inserts or reports full, and a hit on row i ends the scan there.
// Start, clear and an empty read-next go to SEQ_RESP directly; a row read via SEQ_READ.
// Reset clears the row count and the read cursor; table contents are not swept.
// The response sits in an output register, and a new request is accepted
// while an earlier response still waits on rsp_tready.

module packet_log_match_or_insert_table #(
   parameter int unsigned TABLE_DEPTH = 256
) (
   input  wire logic         clock,
   input  wire logic         reset,
   // Request channel.
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // op
   input  wire logic [1:0]   req_tuser,
   // event_time[31:0], protocol[39:32], source_ip[71:40], dest_ip[103:72],
   // source_port[119:104], dest_port[135:120], log_reason[143:136],
   // verdict[144], zero fill[151:145]
   input  wire logic [151:0] req_tdata,
   // Response channel.
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // status
   output logic [2:0]        rsp_tuser,
   // row_time[31:0], row_protocol[39:32], row_source_ip[71:40],
   // row_dest_ip[103:72], row_source_port[119:104], row_dest_port[135:120],
   // row_reason[143:136], row_verdict[144], row_hits[176:145],
   // zero fill[183:177]
   output logic [183:0]      rsp_tdata
);

   import pktlog_pkg::*;

   localparam int unsigned AW = $clog2(TABLE_DEPTH);
   localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

   // Sequencer and table bookkeeping.
   seq_state_type     state_ff, state_in;
   op_type            op_in;
   logic [CW-1:0]     used_ff, used_in;
   logic [CW-1:0]     cursor_ff, cursor_in;
   logic [CW-1:0]     scan_ff, scan_in;
   logic              pend_ff, pend_in;
   logic [AW-1:0]     pend_idx_ff, pend_idx_in;

   // Latched event payload.
   logic [STAMP_W-1:0] ev_stamp_ff, ev_stamp_in;
   logic [ADDRS_W-1:0] ev_addrs_ff, ev_addrs_in;
   logic [CODES_W-1:0] ev_codes_ff, ev_codes_in;

   // Staged result and output register.
   status_type        res_status_ff, res_status_in;
   entry_type         res_entry_ff, res_entry_in;
   logic              rsp_tvalid_ff, rsp_tvalid_in;
   status_type        rsp_status_ff, rsp_status_in;
   entry_type         rsp_entry_ff, rsp_entry_in;

   // Table RAM port.
   logic              ram_we;
   logic [AW-1:0]     ram_waddr;
   entry_type         ram_wdata;
   logic [AW-1:0]     ram_raddr;
   entry_type         ram_rdata;

   logic              req_accept;
   logic              out_free;
   logic              hit;
   logic              scan_done;
   logic              table_full;
   logic              cursor_ok;
   logic [HITS_W-1:0] hits_next;

   pktlog_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // Handshake and status terms.
   assign req_tready = (state_ff == SEQ_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   assign op_in      = op_type'(req_tuser);
   assign table_full = (used_ff == CW'(TABLE_DEPTH));
   assign cursor_ok  = (cursor_ff != '0) && (cursor_ff <= used_ff);

   // The row read last cycle matches on addresses and every code but verdict.
   assign hit = pend_ff && (ram_rdata.addrs == ev_addrs_ff)
                && (ram_rdata.codes[CODES_W-1:1] == ev_codes_ff[CODES_W-1:1]);
   assign scan_done = !pend_ff && (scan_ff >= used_ff);

   // Saturating hit counter.
   assign hits_next = (ram_rdata.hits == '1) ? ram_rdata.hits
                                              : ram_rdata.hits + HITS_W'(1);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         SEQ_IDLE: begin
            if (req_accept) begin
               case (op_in)
                  OP_LOG:  state_in = SEQ_SCAN;
                  OP_READ: state_in = cursor_ok ? SEQ_READ : SEQ_RESP;
                  default: state_in = SEQ_RESP;
               endcase
            end
         end
         SEQ_SCAN: begin
            if (hit || scan_done) begin
               state_in = SEQ_RESP;
            end
         end
         SEQ_READ: state_in = SEQ_RESP;
         SEQ_RESP: begin
            if (out_free) begin
               state_in = SEQ_IDLE;
            end
         end
         default: state_in = SEQ_IDLE;
      endcase
   end

   // Datapath and RAM control.
   always_comb begin
      used_in       = used_ff;
      cursor_in     = cursor_ff;
      scan_in       = scan_ff;
      pend_in       = 1'b0;
      pend_idx_in   = pend_idx_ff;
      ev_stamp_in   = ev_stamp_ff;
      ev_addrs_in   = ev_addrs_ff;
      ev_codes_in   = ev_codes_ff;
      res_status_in = res_status_ff;
      res_entry_in  = res_entry_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_entry_in  = rsp_entry_ff;
      ram_we        = 1'b0;
      ram_waddr     = pend_idx_ff;
      ram_wdata     = ram_rdata;
      ram_raddr     = '0;

      case (state_ff)
         SEQ_IDLE: begin
            if (req_accept) begin
               ev_stamp_in  = req_tdata[31:0];
               ev_addrs_in  = {req_tdata[71:40], req_tdata[103:72]};
               ev_codes_in  = {req_tdata[119:104], req_tdata[135:120],
                               req_tdata[39:32], req_tdata[143:136], req_tdata[144]};
               scan_in      = '0;
               res_entry_in = '0;
               case (op_in)
                  OP_START: begin
                     cursor_in     = used_ff;
                     res_status_in = ST_DONE;
                  end
                  OP_CLEAR: begin
                     used_in       = '0;
                     cursor_in     = '0;
                     res_status_in = ST_DONE;
                  end
                  OP_READ: begin
                     if (cursor_ok) begin
                        ram_raddr     = AW'(cursor_ff - CW'(1));
                        cursor_in     = cursor_ff - CW'(1);
                        res_status_in = ST_ROW;
                     end else begin
                        cursor_in     = '0;
                        res_status_in = ST_NO_MORE;
                     end
                  end
                  default: begin
                     res_status_in = ST_INSERTED;
                  end
               endcase
            end
         end
         SEQ_SCAN: begin
            // Issue one read per cycle while rows remain.
            if (scan_ff < used_ff) begin
               ram_raddr   = scan_ff[AW-1:0];
               pend_in     = 1'b1;
               pend_idx_in = scan_ff[AW-1:0];
               scan_in     = scan_ff + CW'(1);
            end
            if (hit) begin
               // Update in place: new stamp, counted hit, verdict kept.
               ram_we          = 1'b1;
               ram_waddr       = pend_idx_ff;
               ram_wdata       = ram_rdata;
               ram_wdata.stamp = ev_stamp_ff;
               ram_wdata.hits  = hits_next;
               res_status_in   = ST_UPDATED;
            end else if (scan_done) begin
               if (table_full) begin
                  res_status_in = ST_FULL;
               end else begin
                  ram_we        = 1'b1;
                  ram_waddr     = used_ff[AW-1:0];
                  ram_wdata     = '{addrs: ev_addrs_ff, codes: ev_codes_ff,
                                    stamp: ev_stamp_ff, hits: HITS_W'(1)};
                  used_in       = used_ff + CW'(1);
                  res_status_in = ST_INSERTED;
               end
            end
         end
         SEQ_READ: begin
            res_entry_in = ram_rdata;
         end
         SEQ_RESP: begin
            if (out_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_entry_in  = res_entry_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= SEQ_IDLE;
         used_ff       <= '0;
         cursor_ff     <= '0;
         pend_ff       <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         used_ff       <= used_in;
         cursor_ff     <= cursor_in;
         pend_ff       <= pend_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      scan_ff       <= scan_in;
      pend_idx_ff   <= pend_idx_in;
      ev_stamp_ff   <= ev_stamp_in;
      ev_addrs_ff   <= ev_addrs_in;
      ev_codes_ff   <= ev_codes_in;
      res_status_ff <= res_status_in;
      res_entry_ff  <= res_entry_in;
      rsp_status_ff <= rsp_status_in;
      rsp_entry_ff  <= rsp_entry_in;
   end

   // Response packing.
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {7'd0,
                        rsp_entry_ff.hits,
                        rsp_entry_ff.codes[0],
                        rsp_entry_ff.codes[8:1],
                        rsp_entry_ff.codes[32:17],
                        rsp_entry_ff.codes[48:33],
                        rsp_entry_ff.addrs[31:0],
                        rsp_entry_ff.addrs[63:32],
                        rsp_entry_ff.codes[16:9],
                        rsp_entry_ff.stamp};

   // The row count never passes the table depth.
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= CW'(TABLE_DEPTH))
      else $error("row count exceeds table depth");

   // The readout cursor never points past the stored rows.
   a_cursor_bound: assert property (@(posedge clock) disable iff (reset)
      cursor_ff <= used_ff)
      else $error("read cursor beyond stored rows");

   // The table is written only while a log event is being resolved.
   a_write_scan: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == SEQ_SCAN))
      else $error("table write outside scan");

   // An accepted request always leaves the idle state.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff != SEQ_IDLE))
      else $error("accepted request not processed");

endmodule

`default_nettype wire
